>>> rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    // Arena geometry.
    localparam int ARENA_ORDER = 10;
    localparam int ARENA_PAGES = 1 << ARENA_ORDER;
    localparam int ADDR_W      = ARENA_ORDER;
    localparam int ORD_W       = 4;
    localparam int CNT_W       = ARENA_ORDER + 1;

    // Marks a search that found no block.
    localparam logic [ORD_W-1:0] ORD_NONE = '1;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // One entry of the page map.
    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] order;
    } entry_t;

    // Write request into the page map.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    // One result item.
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] start;
        logic [CNT_W-1:0]  pages;
        logic [CNT_W-1:0]  pages_free;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/bpa_mem.sv
`default_nettype none
module bpa_mem (
    input  wire                         clk,
    input  wire bpa_pkg::mem_wr_t       wr,
    input  wire [bpa_pkg::ADDR_W-1:0]   raddr,
    output bpa_pkg::entry_t             rdata
);
    import bpa_pkg::*;

    entry_t mem [ARENA_PAGES];
    entry_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire [bpa_pkg::CNT_W-1:0]    cfg_data,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire                         in_op,
    input  wire [bpa_pkg::CNT_W-1:0]    in_count,
    input  wire [bpa_pkg::ADDR_W-1:0]   in_index,
    output logic                        res_valid,
    input  wire                         res_take,
    output bpa_pkg::result_t            res,
    output bpa_pkg::mem_wr_t            wr,
    output logic [bpa_pkg::ADDR_W-1:0]  raddr,
    input  wire bpa_pkg::entry_t        rdata
);
    import bpa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_MREAD  = 3'd4;
    localparam logic [2:0] S_MCHK   = 3'd5;
    localparam logic [2:0] S_MFIN   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    localparam logic [CNT_W-1:0] ARENA_CNT = CNT_W'(ARENA_PAGES);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              op_reg, op_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ORD_W-1:0]  fo_reg, fo_next;
    logic [ADDR_W-1:0] found_reg, found_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  managed_reg, managed_next;
    logic [CNT_W-1:0]  free_total_reg, free_total_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0]  cnt_fix;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ORD_W-1:0]  in_ord;
    logic [CNT_W-1:0]  in_size;
    logic [CNT_W-1:0]  ord_size;
    logic [CNT_W:0]    in_end;
    logic [CNT_W:0]    blk_end;
    logic [CNT_W:0]    req_end;
    logic [CNT_W:0]    head_end;
    entry_t            init_entry;
    logic [CNT_W-1:0]  head_pos;
    logic [ADDR_W-1:0] bud_addr;
    logic [ORD_W-1:0]  fo_dec;
    logic [ADDR_W-1:0] last_page;

    assign last_page = '1;

    // Rounded order of the incoming count.
    always_comb
    begin
        cnt_fix = (in_count == '0) ? CNT_W'(1) : in_count;
        cnt_m1  = cnt_fix - CNT_W'(1);
        in_ord  = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (cnt_m1[i])
            begin
                in_ord = ORD_W'(i + 1);
            end
        end
        in_size = CNT_W'(1) << in_ord;
        in_end  = {2'b00, in_index} + {1'b0, in_size};
    end

    // Greedy decomposition: a page heads the order-k block when bit k of the
    // managed count is set and the page equals the bits of the count above k.
    always_comb
    begin
        init_entry = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            head_pos = (managed_reg >> (k + 1)) << (k + 1);
            if (managed_reg[k] && head_pos == {1'b0, addr_reg[ADDR_W-1:0]})
            begin
                init_entry.free  = 1'b1;
                init_entry.order = ORD_W'(k);
            end
        end
    end

    assign ord_size = CNT_W'(1) << ord_reg;
    assign req_end  = {2'b00, cur_reg} + {1'b0, ord_size};
    assign head_end = {2'b00, rd_addr_reg} + ({{CNT_W{1'b0}}, 1'b1} << rdata.order);
    assign blk_end  = req_end;
    assign bud_addr = cur_reg ^ (ADDR_W'(1) << ord_reg);
    assign fo_dec   = fo_reg - ORD_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        rd_addr_next    = rd_addr_reg;
        op_next         = op_reg;
        ord_next        = ord_reg;
        cur_next        = cur_reg;
        fo_next         = fo_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        managed_next    = managed_reg;
        free_total_next = free_total_reg;
        res_next        = res_reg;
        wr              = '0;
        raddr           = addr_reg[ADDR_W-1:0];
        cfg_ready       = (state_reg == S_IDLE);
        in_ready        = (state_reg == S_IDLE) && !cfg_valid;
        res_valid       = (state_reg == S_RESULT);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    managed_next = (cfg_data > ARENA_CNT) ? ARENA_CNT : cfg_data;
                    addr_next    = '0;
                    state_next   = S_INIT;
                end
                else if (in_valid)
                begin
                    op_next    = in_op;
                    ord_next   = in_ord;
                    cur_next   = in_index;
                    addr_next  = '0;
                    hit_next   = 1'b0;
                    fo_next    = ORD_NONE;
                    res_next   = '0;
                    res_next.pages_free = free_total_reg;
                    state_next = S_SCAN;
                    if (in_ord > ORD_W'(ARENA_ORDER))
                    begin
                        res_next.status = (in_op == OP_ALLOC) ? ST_NOSPACE : ST_BADFREE;
                        state_next      = S_RESULT;
                    end
                    else if (in_op == OP_FREE &&
                             (((in_index & ADDR_W'(in_size - CNT_W'(1))) != '0) ||
                              (in_end > {1'b0, managed_reg})))
                    begin
                        res_next.status = ST_BADFREE;
                        state_next      = S_RESULT;
                    end
                end
            end

            // Rebuild sweep, one entry a cycle.
            S_INIT:
            begin
                wr.we   = 1'b1;
                wr.addr = addr_reg[ADDR_W-1:0];
                wr.data = init_entry;
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg[ADDR_W-1:0] == last_page)
                begin
                    free_total_next = managed_reg;
                    state_next      = S_IDLE;
                end
            end

            // Full pass over the map: best-fit search or overlap check.
            S_SCAN:
            begin
                if (addr_reg != ARENA_CNT)
                begin
                    rd_vld_next  = 1'b1;
                    rd_addr_next = addr_reg[ADDR_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                end
                if (rd_vld_reg && rdata.free)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (rdata.order >= ord_reg && rdata.order < fo_reg)
                        begin
                            fo_next    = rdata.order;
                            found_next = rd_addr_reg;
                        end
                    end
                    else if ({2'b00, rd_addr_reg} < blk_end &&
                             {2'b00, cur_reg} < head_end)
                    begin
                        hit_next = 1'b1;
                    end
                end
                if (addr_reg == ARENA_CNT && !rd_vld_reg)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (fo_reg == ORD_NONE)
                        begin
                            res_next.status = ST_NOSPACE;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SPLIT;
                        end
                    end
                    else if (hit_reg)
                    begin
                        res_next.status = ST_BADFREE;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_MREAD;
                    end
                end
            end

            // Hand the upper halves back, one per cycle, then claim the head.
            S_SPLIT:
            begin
                wr.we = 1'b1;
                if (fo_reg > ord_reg)
                begin
                    fo_next       = fo_dec;
                    wr.addr       = found_reg + (ADDR_W'(1) << fo_dec);
                    wr.data.free  = 1'b1;
                    wr.data.order = fo_dec;
                end
                else
                begin
                    wr.addr              = found_reg;
                    wr.data.free         = 1'b0;
                    wr.data.order        = ord_reg;
                    free_total_next      = free_total_reg - ord_size;
                    res_next.start       = found_reg;
                    res_next.pages       = ord_size;
                    res_next.pages_free  = free_total_reg - ord_size;
                    state_next           = S_RESULT;
                end
            end

            // Merge chain: fetch the buddy at the current order.
            S_MREAD:
            begin
                raddr = bud_addr;
                if (ord_reg < ORD_W'(ARENA_ORDER))
                begin
                    fo_next    = ord_reg;
                    found_next = bud_addr;
                    state_next = S_MCHK;
                end
                else
                begin
                    state_next = S_MFIN;
                end
            end

            S_MCHK:
            begin
                if (rdata.free && rdata.order == fo_reg)
                begin
                    wr.we         = 1'b1;
                    wr.addr       = found_reg;
                    wr.data.free  = 1'b0;
                    wr.data.order = rdata.order;
                    if (found_reg < cur_reg)
                    begin
                        cur_next = found_reg;
                    end
                    ord_next   = ord_reg + ORD_W'(1);
                    state_next = S_MREAD;
                end
                else
                begin
                    state_next = S_MFIN;
                end
            end

            // Mark the merged block free. The freed size is the original one.
            S_MFIN:
            begin
                wr.we               = 1'b1;
                wr.addr             = cur_reg;
                wr.data.free        = 1'b1;
                wr.data.order       = ord_reg;
                free_total_next     = free_total_reg + res_reg.pages;
                res_next.pages_free = free_total_reg + res_reg.pages;
                state_next          = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The freed size is fixed at entry to the merge chain.
        if (state_reg == S_SCAN && state_next == S_MREAD)
        begin
            res_next.pages = ord_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            managed_reg    <= ARENA_CNT;
            free_total_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rd_vld_reg     <= rd_vld_next;
            managed_reg    <= managed_next;
            free_total_reg <= free_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        op_reg      <= op_next;
        ord_reg     <= ord_next;
        cur_reg     <= cur_next;
        fo_reg      <= fo_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

>>> rtl/buddy_page_allocator.sv
`default_nettype none
// Buddy page allocator over a 1024-page arena. The free map lives in one
// 1024-entry synchronous memory (free flag and order per block head). After
// reset and after every managed_pages write the map is rebuilt by a sweep of
// all 1024 entries, during which no item is taken. An item is taken in the
// idle state. An allocate item then makes one full pass over the map to find
// the lowest free block of the smallest sufficient order, then gives the
// upper half back at each split level and claims the head. A free item makes
// the same pass to reject overlap with free blocks, then checks the buddy at
// each merge level until the chain stops at a buddy that is not free at that
// order or reaches the whole arena. Requests rejected up front skip the pass.
// Every item ends in the result state until the output register takes it, and
// the output register presents the result from the next cycle on. The pass
// over the single memory read port sets the rate. A finished result waits in
// the output register while the next item is accepted.
module buddy_page_allocator (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [10:0]  cfg_data,       // managed_pages
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [23:0]  s_tdata,        // page_count[10:0], page_index[20:11]
    input  wire         s_tuser,        // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata         // status[1:0], block_start[11:2],
                                        // block_pages[22:12], pages_free[33:23]
);
    import bpa_pkg::*;

    mem_wr_t           wr;
    logic [ADDR_W-1:0] raddr;
    entry_t            rdata;
    result_t           res;
    logic              res_valid;
    logic              res_take;
    logic              m_tvalid_reg;
    result_t           out_reg;

    bpa_mem u_mem (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_count  (s_tdata[10:0]),
        .in_index  (s_tdata[20:11]),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .wr        (wr),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    // Output register.
    assign res_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_reg.pages_free, out_reg.pages, out_reg.start, out_reg.status};

endmodule
`default_nettype wire

>>> rtl/bpa_checker.sv
`default_nettype none
module bpa_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);
    // Free page total never exceeds the arena.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:23] <= 11'd1024))
        else $error("free page total beyond arena");

    // Status is one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status");

    // An error carries no block.
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != 2'd0) |-> (m_tdata[22:2] == 21'd0))
        else $error("error result carries a block");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
